// ===== hdl/bmp24_stream_to_lcd_pixels_macros.svh =====
// ----------------------------------------------------------------------------
// BMP24 assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_TO_LCD_PIXELS_MACROS_SVH
`define BMP24_STREAM_TO_LCD_PIXELS_MACROS_SVH

// same-cycle implication
`define BMP24_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp24 assertion failed");

// next-cycle implication
`define BMP24_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp24 assertion failed");

`endif

// ===== hdl/bmp24_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp24_pkg
// Types and constants shared by the BMP stream decoder modules.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    // result status codes
    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_SIG   = 3'd1;
    localparam logic [2:0] ST_DEPTH = 3'd2;
    localparam logic [2:0] ST_SIZE  = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;

    // output_format codes (anything else packs as RGB888)
    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_RESET  = 2'd2;

    localparam logic [7:0]  SIG_B0 = 8'h42;
    localparam logic [7:0]  SIG_B1 = 8'h4D;
    localparam logic [15:0] BPP_24 = 16'd24;

    // header byte positions
    localparam logic [31:0] POS_SIG0   = 32'd0;
    localparam logic [31:0] POS_SIG1   = 32'd1;
    localparam logic [31:0] POS_OFS_LO = 32'd10;
    localparam logic [31:0] POS_OFS_HI = 32'd13;
    localparam logic [31:0] POS_WID_LO = 32'd18;
    localparam logic [31:0] POS_WID_HI = 32'd21;
    localparam logic [31:0] POS_HGT_LO = 32'd22;
    localparam logic [31:0] POS_HGT_HI = 32'd25;
    localparam logic [31:0] POS_BPP_LO = 32'd28;
    localparam logic [31:0] POS_BPP_HI = 32'd29;

    typedef struct packed {
        logic       eof;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] col;
        logic [11:0] row;
        logic [23:0] color;
        logic        last;
    } result_t;

endpackage

// ===== hdl/bmp24_in_reg.sv =====
// ----------------------------------------------------------------------------
// bmp24_in_reg
// Input register: holds one accepted file byte until the decoder takes it.
// ----------------------------------------------------------------------------
module bmp24_in_reg
    import bmp24_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     step,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready = !valid_reg || step;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/bmp24_decode.sv =====
// ----------------------------------------------------------------------------
// bmp24_decode
// Parser state and single-pass byte decode: header capture, skip, pixel pack.
// ----------------------------------------------------------------------------
`include "bmp24_stream_to_lcd_pixels_macros.svh"

module bmp24_decode
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       step,
    input  in_item_t   item,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RH = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t          phase_reg,    phase_next;
    logic [31:0]     pos_reg,      pos_next;
    logic [31:0]     offset_reg,   offset_next;
    logic [31:0]     width_reg,    width_next;
    logic [31:0]     height_reg,   height_next;
    logic [7:0]      bpp_lo_reg,   bpp_lo_next;
    logic [CW-1:0]   col_reg,      col_next;
    logic [RH-1:0]   srow_reg,     srow_next;
    logic [1:0]      pad_reg,      pad_next;
    logic [1:0]      comp_reg,     comp_next;
    logic [7:0]      blue_reg,     blue_next;
    logic [7:0]      green_reg,    green_next;
    logic            first_ok_reg, first_ok_next;
    logic [1:0]      fmt_reg;

    logic            do_pix;
    logic [1:0]      lane;
    logic [CW-1:0]   col_inc;
    logic [RH-1:0]   row_inc;
    logic [31:0]     col_ext;
    logic [31:0]     row_ext;
    logic [7:0]      b;

    assign b       = item.data;
    // header fields start at 10, 18, 22: all two mod four
    assign lane    = pos_reg[1:0] - 2'd2;
    assign col_inc = col_reg + CW'(1);
    assign row_inc = srow_reg + RH'(1);
    assign col_ext = 32'(col_reg);
    assign row_ext = height_reg - 32'd1 - 32'(srow_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        offset_next   = offset_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        bpp_lo_next   = bpp_lo_reg;
        col_next      = col_reg;
        srow_next     = srow_reg;
        pad_next      = pad_reg;
        comp_next     = comp_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        first_ok_next = first_ok_reg;
        res_valid     = 1'b0;
        res           = '0;
        do_pix        = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                pos_next = pos_reg + 32'd1;
                if (pos_reg == POS_SIG0)
                begin
                    first_ok_next = (b == SIG_B0);
                end
                else if (pos_reg == POS_SIG1)
                begin
                    if (!(first_ok_reg && b == SIG_B1))
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = ST_SIG;
                    end
                end
                else if (pos_reg >= POS_OFS_LO && pos_reg <= POS_OFS_HI)
                begin
                    offset_next[{lane, 3'b000} +: 8] = b;
                end
                else if (pos_reg >= POS_WID_LO && pos_reg <= POS_WID_HI)
                begin
                    width_next[{lane, 3'b000} +: 8] = b;
                end
                else if (pos_reg >= POS_HGT_LO && pos_reg <= POS_HGT_HI)
                begin
                    height_next[{lane, 3'b000} +: 8] = b;
                end
                else if (pos_reg == POS_BPP_LO)
                begin
                    bpp_lo_next = b;
                end
                else if (pos_reg == POS_BPP_HI)
                begin
                    if ({b, bpp_lo_reg} != BPP_24)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = ST_DEPTH;
                    end
                    else if (width_reg > 32'(MAX_WIDTH) || height_reg > 32'(MAX_HEIGHT))
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = ST_SIZE;
                    end
                    else if (width_reg == 32'd0 || height_reg == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                pos_next = pos_reg + 32'd1;
                if (pos_reg >= offset_reg)
                begin
                    phase_next = PH_PIXEL;
                    do_pix     = 1'b1;
                end
            end
            PH_PIXEL:
            begin
                pos_next = pos_reg + 32'd1;
                do_pix   = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_pix)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (comp_reg == 2'd0)
            begin
                blue_next = b;
                comp_next = 2'd1;
            end
            else if (comp_reg == 2'd1)
            begin
                green_next = b;
                comp_next  = 2'd2;
            end
            else
            begin
                comp_next  = 2'd0;
                res_valid  = 1'b1;
                res.status = ST_PIXEL;
                res.col    = col_ext[11:0];
                res.row    = row_ext[11:0];
                if (fmt_reg == FMT_RGB565)
                begin
                    res.color = {8'h00, b[7:3], green_reg[7:2], blue_reg[7:3]};
                end
                else
                begin
                    res.color = {b, green_reg, blue_reg};
                end
                // end of row: rows are padded to a multiple of four bytes
                if (col_inc >= width_reg[CW-1:0])
                begin
                    col_next  = '0;
                    pad_next  = width_reg[1:0];
                    srow_next = row_inc;
                    if (row_inc >= height_reg[RH-1:0])
                    begin
                        phase_next = PH_DONE;
                        res.last   = 1'b1;
                    end
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end

        if (item.eof)
        begin
            // incomplete image wins over a pixel finished by the final byte
            if (phase_next != PH_DONE && phase_next != PH_ERROR)
            begin
                res        = '0;
                res.status = ST_TRUNC;
                res_valid  = 1'b1;
            end
            phase_next    = PH_HEADER;
            pos_next      = '0;
            offset_next   = '0;
            width_next    = '0;
            height_next   = '0;
            bpp_lo_next   = '0;
            col_next      = '0;
            srow_next     = '0;
            pad_next      = '0;
            comp_next     = '0;
            blue_next     = '0;
            green_next    = '0;
            first_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            offset_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_lo_reg   <= '0;
            col_reg      <= '0;
            srow_reg     <= '0;
            pad_reg      <= '0;
            comp_reg     <= '0;
            blue_reg     <= '0;
            green_reg    <= '0;
            first_ok_reg <= 1'b0;
            fmt_reg      <= FMT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fmt_reg <= cfg_wr_data;
            end
            if (step)
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                offset_reg   <= offset_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                bpp_lo_reg   <= bpp_lo_next;
                col_reg      <= col_next;
                srow_reg     <= srow_next;
                pad_reg      <= pad_next;
                comp_reg     <= comp_next;
                blue_reg     <= blue_next;
                green_reg    <= green_next;
                first_ok_reg <= first_ok_next;
            end
        end
    end

    `BMP24_ASSERT_NOW(a_idle_silent, step && (phase_reg == PH_DONE || phase_reg == PH_ERROR), !res_valid)
    `BMP24_ASSERT_NEXT(a_eof_rearm, step && item.eof, phase_reg == PH_HEADER && pos_reg == 32'd0)
    `BMP24_ASSERT_NEXT(a_last_done, step && res_valid && res.last, phase_reg == PH_DONE || phase_reg == PH_HEADER)
    `BMP24_ASSERT_NOW(a_col_range, phase_reg == PH_PIXEL, col_reg < width_reg[CW-1:0])

endmodule

// ===== hdl/bmp24_out_reg.sv =====
// ----------------------------------------------------------------------------
// bmp24_out_reg
// Result register: holds one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module bmp24_out_reg
    import bmp24_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== hdl/bmp24_stream_to_lcd_pixels.sv =====
// An accepted byte's result is registered in the result register. Throughput:
// one file byte per cycle while the sink keeps m_tready high; the decode step
// fires whenever a byte is held and the result register is empty or being
// drained. Reset: rst_n is asynchronous, active low; the parser returns to the
// header phase, output_format returns to 2 (RGB888) and both registers empty.
// ----------------------------------------------------------------------------
// bmp24_stream_to_lcd_pixels
// Streaming 24-bit BMP decoder producing RGB565 or RGB888 pixels with x/y.
// ----------------------------------------------------------------------------
module bmp24_stream_to_lcd_pixels
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // output_format
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] file_byte
    input  logic        s_tlast,       // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [11:0] pixel_column, [23:12] pixel_row,
                                       // [47:24] pixel_color
    output logic [2:0]  m_tuser,       // [2:0] status
    output logic        m_tlast        // last_pixel
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     step;
    logic     res_valid;
    result_t  res;
    result_t  res_out;

    assign in_item.data = s_tdata;
    assign in_item.eof  = s_tlast;

    // one request moves through decode when the result slot is free or being drained
    assign step = item_valid && (!m_tvalid || m_tready);

    bmp24_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    bmp24_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res)
    );

    bmp24_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res_in    (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .res_out   (res_out)
    );

    assign m_tdata = {res_out.color, res_out.row, res_out.col};
    assign m_tuser = res_out.status;
    assign m_tlast = res_out.last;

endmodule
